// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TLMP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TLMP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tlmp_pkg.sv =====
// ----------------------------------------------------------------------------
// tlmp_pkg
// Shared types and constants of the two-level load miss predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package tlmp_pkg;

  localparam int TLMP_PC_ENTRIES      = 1024;
  localparam int TLMP_HISTORY_ENTRIES = 1024;
  localparam int PC_W                 = 64;
  localparam int CNT_W                = 32;

  typedef enum logic {
    OP_PREDICT = 1'b0,
    OP_UPDATE  = 1'b1
  } op_t;

  // Word handed from the history stage to the pattern stage.
  typedef struct packed {
    logic valid;
    logic upd;
    logic miss;
  } req_t;

endpackage

`default_nettype wire

// ===== rtl/two_level_load_miss_predictor_top.sv =====
// ----------------------------------------------------------------------------
// two_level_load_miss_predictor_top
// Two-level load miss predictor: per-address history, shared pattern table.
// ----------------------------------------------------------------------------
// Takes one predict or update word per cycle, while the output is taken and no
// clear runs, and returns one result word per input, in order, after the
// history table read at acceptance, the pattern table read and the result
// register. Back-to-back accesses to the same address or history are bypassed,
// so throughput stays at one word per cycle while the output is taken. After
// reset both tables are zeroed by a sweep over max(PC_ENTRIES, HISTORY_ENTRIES)
// entries through their single write ports; in_ready stays low for that time.
`default_nettype none

module two_level_load_miss_predictor_top #(
  parameter int PC_ENTRIES      = tlmp_pkg::TLMP_PC_ENTRIES,
  parameter int HISTORY_ENTRIES = tlmp_pkg::TLMP_HISTORY_ENTRIES
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          op,
  input  wire [tlmp_pkg::PC_W-1:0]     pc,
  input  wire                          miss,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         predicted_miss,
  output logic                         update_agreed,
  output logic [tlmp_pkg::CNT_W-1:0]   agree_count,
  output logic [tlmp_pkg::CNT_W-1:0]   disagree_count
);
  import tlmp_pkg::*;

  localparam int PCB         = $clog2(PC_ENTRIES);
  localparam int HB          = $clog2(HISTORY_ENTRIES);
  localparam int CLR_ENTRIES = (PC_ENTRIES > HISTORY_ENTRIES) ? PC_ENTRIES : HISTORY_ENTRIES;
  localparam int CB          = $clog2(CLR_ENTRIES);

  logic          clearing;
  logic [CB-1:0] clr_cnt;
  logic          adv;
  logic          load;
  req_t          req;
  logic [HB-1:0] req_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + CB'(1);
      if (clr_cnt == CB'(CLR_ENTRIES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = !clearing && (adv || !req.valid);
  assign load     = in_valid && in_ready;

  tlmp_hist #(
    .PC_ENTRIES      (PC_ENTRIES),
    .HISTORY_ENTRIES (HISTORY_ENTRIES)
  ) u_hist (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .adv      (adv),
    .in_op    (op),
    .in_slot  (pc[PCB-1:0]),
    .in_miss  (miss),
    .clr      (clearing),
    .clr_idx  (clr_cnt[PCB-1:0]),
    .req      (req),
    .req_addr (req_addr)
  );

  tlmp_pattern #(
    .HISTORY_ENTRIES (HISTORY_ENTRIES)
  ) u_pattern (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .clr            (clearing),
    .clr_idx        (clr_cnt[HB-1:0]),
    .req            (req),
    .req_addr       (req_addr),
    .out_valid      (out_valid),
    .predicted_miss (predicted_miss),
    .update_agreed  (update_agreed),
    .agree_count    (agree_count),
    .disagree_count (disagree_count)
  );

endmodule

`default_nettype wire

// ===== rtl/tlmp_hist.sv =====
// ----------------------------------------------------------------------------
// tlmp_hist
// History stage: per-address miss history table, bypass of the write made
// on the same edge as the read, and pattern table address generation.
// ----------------------------------------------------------------------------
`default_nettype none

module tlmp_hist #(
  parameter int PC_ENTRIES      = 1024,
  parameter int HISTORY_ENTRIES = 1024
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 load,
  input  wire                                 adv,
  input  wire                                 in_op,
  input  wire [$clog2(PC_ENTRIES)-1:0]        in_slot,
  input  wire                                 in_miss,
  input  wire                                 clr,
  input  wire [$clog2(PC_ENTRIES)-1:0]        clr_idx,
  output tlmp_pkg::req_t                      req,
  output logic [$clog2(HISTORY_ENTRIES)-1:0]  req_addr
);
  import tlmp_pkg::*;

  localparam int PCB = $clog2(PC_ENTRIES);
  localparam int HB  = $clog2(HISTORY_ENTRIES);

  logic [HB-1:0]  hist_mem [PC_ENTRIES];
  logic [HB-1:0]  hist_rd;
  logic           s1_valid;
  logic           s1_upd;
  logic           s1_miss;
  logic [PCB-1:0] s1_slot;
  logic           fw_valid;
  logic [PCB-1:0] fw_slot;
  logic [HB-1:0]  fw_hist;
  logic           s1_en;
  logic           wr_en;
  logic [HB-1:0]  hist_cur;
  logic [HB:0]    hist_ext;
  logic [HB-1:0]  hist_new;

  assign s1_en = adv || !s1_valid;
  assign wr_en = adv && s1_valid && s1_upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_upd  <= (op_t'(in_op) == OP_UPDATE);
      s1_miss <= in_miss;
      s1_slot <= in_slot;
      hist_rd <= hist_mem[in_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      hist_mem[clr_idx] <= '0;
    end else if (wr_en) begin
      hist_mem[s1_slot] <= hist_new;
    end
  end

  // Remember the last write so a read on the same edge sees it.
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      fw_valid <= 1'b0;
    end else if (adv) begin
      fw_valid <= s1_valid && s1_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fw_slot <= s1_slot;
      fw_hist <= hist_new;
    end
  end

  always_comb begin
    hist_cur  = (fw_valid && (fw_slot == s1_slot)) ? fw_hist : hist_rd;
    hist_ext  = {hist_cur, s1_miss};
    hist_new  = hist_ext[HB-1:0];
    req.valid = s1_valid;
    req.upd   = s1_upd;
    req.miss  = s1_miss;
    req_addr  = s1_upd ? hist_new : hist_cur;
  end

endmodule

`default_nettype wire

// ===== rtl/tlmp_pattern.sv =====
// ----------------------------------------------------------------------------
// tlmp_pattern
// Pattern stage: shared pattern table, same-edge write bypass, saturating
// agreement counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlmp_pattern #(
  parameter int HISTORY_ENTRIES = 1024
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 adv,
  input  wire                                 clr,
  input  wire [$clog2(HISTORY_ENTRIES)-1:0]   clr_idx,
  input  tlmp_pkg::req_t                      req,
  input  wire [$clog2(HISTORY_ENTRIES)-1:0]   req_addr,
  output logic                                out_valid,
  output logic                                predicted_miss,
  output logic                                update_agreed,
  output logic [tlmp_pkg::CNT_W-1:0]          agree_count,
  output logic [tlmp_pkg::CNT_W-1:0]          disagree_count
);
  import tlmp_pkg::*;

  localparam int HB = $clog2(HISTORY_ENTRIES);

  logic             pat_mem [HISTORY_ENTRIES];
  logic             pat_rd;
  req_t             s2;
  logic [HB-1:0]    s2_addr;
  logic             fw_valid;
  logic [HB-1:0]    fw_addr;
  logic             fw_bit;
  logic             old_bit;
  logic             train;
  logic             agreed;

  assign train  = adv && s2.valid && s2.upd;
  assign old_bit = (fw_valid && (fw_addr == s2_addr)) ? fw_bit : pat_rd;
  assign agreed  = (old_bit == s2.miss);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (adv) begin
      s2.valid <= req.valid;
    end
    if (adv) begin
      s2.upd  <= req.upd;
      s2.miss <= req.miss;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_addr <= req_addr;
      pat_rd  <= pat_mem[req_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      pat_mem[clr_idx] <= 1'b0;
    end else if (train) begin
      pat_mem[s2_addr] <= s2.miss;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      fw_valid <= 1'b0;
    end else if (adv) begin
      fw_valid <= s2.valid && s2.upd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fw_addr <= s2_addr;
      fw_bit  <= s2.miss;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      agree_count    <= '0;
      disagree_count <= '0;
    end else if (adv) begin
      out_valid <= s2.valid;
      if (train && agreed && (agree_count != '1)) begin
        agree_count <= agree_count + CNT_W'(1);
      end
      if (train && !agreed && (disagree_count != '1)) begin
        disagree_count <= disagree_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      predicted_miss <= s2.upd ? s2.miss : old_bit;
      update_agreed  <= s2.upd && agreed;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tlmp_checker.sv =====
// ----------------------------------------------------------------------------
// tlmp_checker
// Port-level checks of the load miss predictor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tlmp_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire                          update_agreed,
  input wire [tlmp_pkg::CNT_W-1:0]    agree_count,
  input wire [tlmp_pkg::CNT_W-1:0]    disagree_count
);

  property p_cnt_stall;
    out_valid && !out_ready |=> $stable(agree_count) && $stable(disagree_count);
  endproperty

  property p_cnt_mono;
    $past(!rst) |-> agree_count >= $past(agree_count) &&
                    disagree_count >= $past(disagree_count);
  endproperty

  `TLMP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result word dropped")
  `TLMP_ASSERT(a_cnt_stall, p_cnt_stall, "counters moved under stall")
  `TLMP_ASSERT(a_cnt_mono, p_cnt_mono, "counter decreased")
  `TLMP_ASSERT(a_agree_cnt, out_valid && update_agreed |-> agree_count != '0, "agreement lost")
  `TLMP_ASSERT(a_clear_busy, $past(rst) |-> !in_ready && !out_valid, "busy during table clear")

endmodule

bind two_level_load_miss_predictor_top tlmp_checker u_checker (.*);

`default_nettype wire
